// File: hdl/h2r_pkg.sv
// Shared constants and types for the HSL to RGB fixed point core.
// Used by h2r_mix, h2r_chan and hsl_to_rgb_fixed_point_core; no dependencies.
`timescale 1ns / 1ps

package h2r_pkg;

  localparam int unsigned FxOne   = 65536;
  localparam int unsigned FxSixth = FxOne / 6;
  localparam int unsigned FxThird = FxOne / 3;
  localparam int unsigned FxHalf  = FxOne / 2;
  localparam int unsigned FxTwo3  = (FxOne * 2) / 3;
  localparam int unsigned FxSix   = FxOne * 6;
  localparam int unsigned SixInt  = FxSix / FxOne;

  typedef enum logic [1:0] {
    SHIFT_UP   = 2'd0,
    SHIFT_NONE = 2'd1,
    SHIFT_DOWN = 2'd2
  } shift_e;

  typedef enum logic [1:0] {
    SEG_RISE = 2'd0,
    SEG_HIGH = 2'd1,
    SEG_FALL = 2'd2,
    SEG_LOW  = 2'd3
  } seg_e;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } en_t;

  typedef struct packed {
    logic signed [19:0] x;
    logic signed [19:0] y;
    logic               dneg;
    logic [18:0]        dmag;
  } mix_t;

endpackage

// File: hdl/h2r_mix.sv
// Stages one and two: lightness times saturation, then the x, y and y - x terms.
// Depends on h2r_pkg.
`timescale 1ns / 1ps

module h2r_mix (
  input  logic          clk_i,
  input  h2r_pkg::en_t  en_i,
  input  logic [15:0]   hue_i,
  input  logic [15:0]   saturation_i,
  input  logic [15:0]   lightness_i,
  output logic [15:0]   hue_o,
  output logic          grey_o,
  output logic [15:0]   light_o,
  output h2r_pkg::mix_t mix_o
);

  logic [15:0]        hue_q;
  logic [15:0]        sat_q;
  logic [15:0]        light_q;
  logic [15:0]        prod_q;
  logic               grey1_q;
  logic [31:0]        prod_full;

  logic               grey2_q;
  logic [15:0]        light2_q;
  h2r_pkg::mix_t      mix_q;
  h2r_pkg::mix_t      mix_d;

  logic signed [19:0] l_s;
  logic signed [19:0] s_s;
  logic signed [19:0] p_s;
  logic signed [19:0] y_d;
  logic signed [19:0] x_d;
  logic signed [19:0] d_d;
  logic signed [19:0] dn_d;

  assign prod_full = 32'(lightness_i) * 32'(saturation_i);

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      hue_q   <= hue_i;
      sat_q   <= saturation_i;
      light_q <= lightness_i;
      prod_q  <= prod_full[31:16];
      grey1_q <= (saturation_i == 16'd0);
    end
  end

  always_comb begin
    l_s = signed'({4'b0000, light_q});
    s_s = signed'({4'b0000, sat_q});
    p_s = signed'({4'b0000, prod_q});
    if ({1'b0, light_q} <= 17'(h2r_pkg::FxHalf)) begin
      y_d = l_s + p_s;
    end else begin
      y_d = l_s + s_s - p_s;
    end
    x_d  = (l_s <<< 1) - y_d;
    d_d  = y_d - x_d;
    dn_d = -d_d;
    mix_d.x    = x_d;
    mix_d.y    = y_d;
    mix_d.dneg = d_d[19];
    mix_d.dmag = d_d[19] ? dn_d[18:0] : d_d[18:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      mix_q    <= mix_d;
      grey2_q  <= grey1_q;
      light2_q <= light_q;
    end
  end

  assign hue_o   = hue_q;
  assign grey_o  = grey2_q;
  assign light_o = light2_q;
  assign mix_o   = mix_q;

endmodule

// File: hdl/h2r_chan.sv
// One color channel: hue wrap and ramp segment, ramp multiply, final add and clamp.
// Depends on h2r_pkg; takes the stage-two terms from h2r_mix.
`timescale 1ns / 1ps

module h2r_chan (
  input  logic            clk_i,
  input  h2r_pkg::en_t    en_i,
  input  h2r_pkg::shift_e shift_i,
  input  logic [15:0]     hue_i,
  input  h2r_pkg::mix_t   mix_i,
  output logic [15:0]     val_o
);

  logic signed [17:0] hs;
  logic signed [17:0] hw;
  logic [16:0]        hu;
  h2r_pkg::seg_e      seg_d;
  logic [18:0]        t_full;
  logic [15:0]        t_d;

  h2r_pkg::seg_e      seg2_q;
  logic [15:0]        t2_q;

  logic [34:0]        prod;
  h2r_pkg::seg_e      seg3_q;
  logic [18:0]        m3_q;
  logic               neg3_q;
  logic signed [19:0] x3_q;
  logic signed [19:0] y3_q;

  logic signed [20:0] m_s;
  logic signed [20:0] off;
  logic signed [20:0] r;

  always_comb begin
    case (shift_i)
      h2r_pkg::SHIFT_UP:   hs = signed'({2'b00, hue_i}) + 18'(h2r_pkg::FxThird);
      h2r_pkg::SHIFT_DOWN: hs = signed'({2'b00, hue_i}) - 18'(h2r_pkg::FxThird);
      default:             hs = signed'({2'b00, hue_i});
    endcase
    if (hs < 0) begin
      hw = hs + 18'(h2r_pkg::FxOne);
    end else if (hs > signed'(18'(h2r_pkg::FxOne))) begin
      hw = hs - 18'(h2r_pkg::FxOne);
    end else begin
      hw = hs;
    end
    hu = hw[16:0];
    if (hu < 17'(h2r_pkg::FxSixth)) begin
      seg_d  = h2r_pkg::SEG_RISE;
      t_full = 19'(hu) * 19'(h2r_pkg::SixInt);
    end else if (hu < 17'(h2r_pkg::FxHalf)) begin
      seg_d  = h2r_pkg::SEG_HIGH;
      t_full = '0;
    end else if (hu < 17'(h2r_pkg::FxTwo3)) begin
      seg_d  = h2r_pkg::SEG_FALL;
      t_full = (19'(h2r_pkg::FxTwo3) - 19'(hu)) * 19'(h2r_pkg::SixInt);
    end else begin
      seg_d  = h2r_pkg::SEG_LOW;
      t_full = '0;
    end
    t_d = t_full[15:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      seg2_q <= seg_d;
      t2_q   <= t_d;
    end
  end

  assign prod = 35'(mix_i.dmag) * 35'(t2_q);

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      seg3_q <= seg2_q;
      m3_q   <= prod[34:16];
      neg3_q <= mix_i.dneg;
      x3_q   <= mix_i.x;
      y3_q   <= mix_i.y;
    end
  end

  always_comb begin
    m_s = signed'({2'b00, m3_q});
    off = neg3_q ? -m_s : m_s;
    case (seg3_q)
      h2r_pkg::SEG_RISE,
      h2r_pkg::SEG_FALL: r = {x3_q[19], x3_q} + off;
      h2r_pkg::SEG_HIGH: r = {y3_q[19], y3_q};
      default:           r = {x3_q[19], x3_q};
    endcase
    if (r[20]) begin
      val_o = 16'd0;
    end else if (r > 21'sd65535) begin
      val_o = 16'hFFFF;
    end else begin
      val_o = r[15:0];
    end
  end

endmodule

// File: hdl/hsl_to_rgb_fixed_point_core.sv
// Top level of the HSL to RGB fixed point core: stage control and output register.
// Depends on h2r_pkg, h2r_mix and h2r_chan.
`timescale 1ns / 1ps

// Usage:
// A request on the input channel carries hue_i, saturation_i and lightness_i;
// it is taken at a rising edge with in_valid_i high and in_stall_o low.
// Each request gives one result, red_o, green_o and blue_o, offered with
// out_valid_o and taken at an edge where out_stall_i is low.
// The datapath is a four-stage pipeline: lightness times saturation, the
// x/y terms and hue segment, the ramp multiply, then add, clamp and the
// output register. Each multiplier has a stage of its own.
// Throughput is one request per cycle while out_stall_i stays low.
// When out_stall_i is high the output holds; empty stages still fill, and
// in_stall_o rises only once every stage holds a request.
// Reset clears all stage valid bits; no request is in flight afterwards.
// Zero saturation passes lightness to all three outputs.

module hsl_to_rgb_fixed_point_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] hue_i,
  input  logic [15:0] saturation_i,
  input  logic [15:0] lightness_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] red_o,
  output logic [15:0] green_o,
  output logic [15:0] blue_o
);

  logic          v1_q, v2_q, v3_q, v4_q;
  logic          v1_d, v2_d, v3_d, v4_d;
  h2r_pkg::en_t  en;

  logic [15:0]   hue1;
  logic          grey2;
  logic [15:0]   light2;
  h2r_pkg::mix_t mix2;

  logic          grey3_q;
  logic [15:0]   light3_q;
  logic [15:0]   r_val, g_val, b_val;
  logic [15:0]   red_q, green_q, blue_q;

  assign en.s4 = !v4_q || !out_stall_i;
  assign en.s3 = !v3_q || en.s4;
  assign en.s2 = !v2_q || en.s3;
  assign en.s1 = !v1_q || en.s2;

  assign in_stall_o = !en.s1;

  assign v1_d = en.s1 ? in_valid_i : v1_q;
  assign v2_d = en.s2 ? v1_q : v2_q;
  assign v3_d = en.s3 ? v2_q : v3_q;
  assign v4_d = en.s4 ? v3_q : v4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
      v3_q <= v3_d;
      v4_q <= v4_d;
    end
  end

  h2r_mix u_mix (
    .clk_i        (clk_i),
    .en_i         (en),
    .hue_i        (hue_i),
    .saturation_i (saturation_i),
    .lightness_i  (lightness_i),
    .hue_o        (hue1),
    .grey_o       (grey2),
    .light_o      (light2),
    .mix_o        (mix2)
  );

  h2r_chan u_chan_red (
    .clk_i   (clk_i),
    .en_i    (en),
    .shift_i (h2r_pkg::SHIFT_UP),
    .hue_i   (hue1),
    .mix_i   (mix2),
    .val_o   (r_val)
  );

  h2r_chan u_chan_green (
    .clk_i   (clk_i),
    .en_i    (en),
    .shift_i (h2r_pkg::SHIFT_NONE),
    .hue_i   (hue1),
    .mix_i   (mix2),
    .val_o   (g_val)
  );

  h2r_chan u_chan_blue (
    .clk_i   (clk_i),
    .en_i    (en),
    .shift_i (h2r_pkg::SHIFT_DOWN),
    .hue_i   (hue1),
    .mix_i   (mix2),
    .val_o   (b_val)
  );

  always_ff @(posedge clk_i) begin
    if (en.s3) begin
      grey3_q  <= grey2;
      light3_q <= light2;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en.s4) begin
      red_q   <= grey3_q ? light3_q : r_val;
      green_q <= grey3_q ? light3_q : g_val;
      blue_q  <= grey3_q ? light3_q : b_val;
    end
  end

  assign out_valid_o = v4_q;
  assign red_o       = red_q;
  assign green_o     = green_q;
  assign blue_o      = blue_q;

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (v1_q && v2_q && v3_q && v4_q && out_stall_i))
    else $error("input stalled with a free stage");

  a_empty_front: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v1_q |-> !in_stall_o)
    else $error("input stalled with stage one empty");

  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |=> (out_valid_o == $past(v3_q)))
    else $error("output stage did not advance");

  a_grey: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && en.s4 && grey3_q) |=>
      (red_o == green_o && green_o == blue_o && red_o == $past(light3_q)))
    else $error("grey request gave unequal channels");

endmodule

// File: tb/tb.sv
// Testbench for hsl_to_rgb_fixed_point_core: directed edge cases, then random HSL requests.
// Expected colors come from the typed edge rows or a fixed-point predictor kept here; needs only the RTL.
`timescale 1ns / 1ps

module tb;

  localparam longint Q16One   = 65536;
  localparam longint Q16Sixth = 10922;
  localparam longint Q16Third = 21845;
  localparam longint Q16Half  = 32768;
  localparam longint Q16Two3  = 43690;
  localparam longint Q16Six   = 393216;
  localparam int     RandomRequests = 1200;
  localparam int     CalmTail       = 200;
  localparam int     IdleLimit      = 1000;
  localparam int     DrainCycles    = 12;
  localparam int     ReportLimit    = 10;

  typedef struct {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
  } rgb_t;

  typedef struct {
    logic [15:0] hue;
    logic [15:0] sat;
    logic [15:0] light;
    bit          typed;
    rgb_t        rgb;
  } hsl_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [15:0] hue_i;
  logic [15:0] saturation_i;
  logic [15:0] lightness_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [15:0] red_o;
  logic [15:0] green_o;
  logic [15:0] blue_o;

  rgb_t rgb_pending[$];
  int   requests_sent;
  int   colors_checked;
  int   bad_colors;
  int   idle_cycles;
  int   stall_left;
  bit   calm;

  hsl_row_t edge_rows[24] = '{
    '{16'd0,     16'd0,     16'd0,     1'b1, '{16'd0,     16'd0,     16'd0}},
    '{16'd65535, 16'd0,     16'd65535, 1'b1, '{16'd65535, 16'd65535, 16'd65535}},
    '{16'd21845, 16'd0,     16'd12345, 1'b1, '{16'd12345, 16'd12345, 16'd12345}},
    '{16'd0,     16'd65535, 16'd0,     1'b1, '{16'd0,     16'd0,     16'd0}},
    '{16'd43690, 16'd65535, 16'd0,     1'b1, '{16'd0,     16'd0,     16'd0}},
    '{16'd0,     16'd65535, 16'd65535, 1'b0, '{16'd0, 16'd0, 16'd0}},
    '{16'd0,     16'd65535, 16'd32768, 1'b0, '{16'd0, 16'd0, 16'd0}},
    '{16'd0,     16'd65535, 16'd32769, 1'b0, '{16'd0, 16'd0, 16'd0}},
    '{16'd43691, 16'd65535, 16'd32768, 1'b0, '{16'd0, 16'd0, 16'd0}},
    '{16'd65535, 16'd65535, 16'd32768, 1'b0, '{16'd0, 16'd0, 16'd0}},
    '{16'd21844, 16'd32768, 16'd32768, 1'b0, '{16'd0, 16'd0, 16'd0}},
    '{16'd21845, 16'd32768, 16'd32768, 1'b0, '{16'd0, 16'd0, 16'd0}},
    '{16'd10921, 16'd65535, 16'd32768, 1'b0, '{16'd0, 16'd0, 16'd0}},
    '{16'd10922, 16'd65535, 16'd32768, 1'b0, '{16'd0, 16'd0, 16'd0}},
    '{16'd32767, 16'd65535, 16'd32768, 1'b0, '{16'd0, 16'd0, 16'd0}},
    '{16'd32768, 16'd65535, 16'd32768, 1'b0, '{16'd0, 16'd0, 16'd0}},
    '{16'd43689, 16'd65535, 16'd32768, 1'b0, '{16'd0, 16'd0, 16'd0}},
    '{16'd43690, 16'd65535, 16'd32768, 1'b0, '{16'd0, 16'd0, 16'd0}},
    '{16'd1,     16'd1,     16'd1,     1'b0, '{16'd0, 16'd0, 16'd0}},
    '{16'd65535, 16'd1,     16'd65535, 1'b0, '{16'd0, 16'd0, 16'd0}},
    '{16'd0,     16'd65535, 16'd1,     1'b0, '{16'd0, 16'd0, 16'd0}},
    '{16'd54613, 16'd40000, 16'd20000, 1'b0, '{16'd0, 16'd0, 16'd0}},
    '{16'd12345, 16'd65535, 16'd40000, 1'b0, '{16'd0, 16'd0, 16'd0}},
    '{16'd65534, 16'd30000, 16'd65534, 1'b0, '{16'd0, 16'd0, 16'd0}}
  };

  longint hue_marks[8] = '{0, 10922, 21845, 32768, 43690, 43691, 54613, 65535};

  hsl_to_rgb_fixed_point_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .hue_i       (hue_i),
    .saturation_i(saturation_i),
    .lightness_i (lightness_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o)
  );

  function automatic longint mul_q16(input longint a, input longint b);
    bit [31:0] ua;
    bit [31:0] ub;
    bit [31:0] am;
    bit [31:0] bm;
    bit [31:0] acc;
    bit        neg;
    ua  = a[31:0];
    ub  = b[31:0];
    neg = ua[31] ^ ub[31];
    am  = ua[31] ? 32'd0 - ua : ua;
    bm  = ub[31] ? 32'd0 - ub : ub;
    acc = ({16'd0, am[31:16]} * {16'd0, bm[31:16]}) << 16;
    acc += {16'd0, am[15:0]} * {16'd0, bm[31:16]};
    acc += {16'd0, am[31:16]} * {16'd0, bm[15:0]};
    acc += ({16'd0, am[15:0]} * {16'd0, bm[15:0]}) >> 16;
    if (neg) begin
      acc = 32'd0 - acc;
    end
    return longint'($signed(acc));
  endfunction

  function automatic logic [15:0] ramp_q16(input longint x, input longint y, input longint h);
    longint r;
    if (h < 0) begin
      h += Q16One;
    end
    if (h > Q16One) begin
      h -= Q16One;
    end
    if (h < Q16Sixth) begin
      r = x + mul_q16(y - x, mul_q16(h, Q16Six));
    end else if (h < Q16Half) begin
      r = y;
    end else if (h < Q16Two3) begin
      r = x + mul_q16(y - x, mul_q16(Q16Two3 - h, Q16Six));
    end else begin
      r = x;
    end
    if (r < 0) begin
      return 16'd0;
    end
    if (r > 65535) begin
      return 16'hFFFF;
    end
    return r[15:0];
  endfunction

  function automatic rgb_t rgb_of_hsl(input logic [15:0] hue, input logic [15:0] sat,
                                      input logic [15:0] light);
    longint h;
    longint s;
    longint l;
    longint x;
    longint y;
    rgb_t   c;
    h = hue;
    s = sat;
    l = light;
    if (s == 0) begin
      c.red   = light;
      c.green = light;
      c.blue  = light;
      return c;
    end
    if (l <= Q16Half) begin
      y = l + mul_q16(l, s);
    end else begin
      y = (l + s) - mul_q16(l, s);
    end
    x = (l + l) - y;
    c.red   = ramp_q16(x, y, h + Q16Third);
    c.green = ramp_q16(x, y, h);
    c.blue  = ramp_q16(x, y, h - Q16Third);
    return c;
  endfunction

  function automatic logic [15:0] pick_level();
    case ($urandom_range(0, 7))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'(32767 + $urandom_range(0, 2));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_hue();
    if ($urandom_range(0, 3) == 0) begin
      return 16'(hue_marks[$urandom_range(0, 7)] + $urandom_range(0, 2) - 1);
    end
    return 16'($urandom);
  endfunction

  task automatic send_request(input hsl_row_t row);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    hue_i        <= row.hue;
    saturation_i <= row.sat;
    lightness_i  <= row.light;
    do @(posedge clk_i); while (in_stall_o);
    rgb_pending.push_back(row.typed ? row.rgb : rgb_of_hsl(row.hue, row.sat, row.light));
    requests_sent++;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || calm) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= $urandom_range(0, 4);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    rgb_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (rgb_pending.size() == 0) begin
          bad_colors++;
          if (bad_colors <= ReportLimit) begin
            $display("tb: unexpected color r=%0d g=%0d b=%0d", red_o, green_o, blue_o);
          end
        end else begin
          want = rgb_pending.pop_front();
          colors_checked++;
          if (red_o !== want.red || green_o !== want.green || blue_o !== want.blue) begin
            bad_colors++;
            if (bad_colors <= ReportLimit) begin
              $display("tb: color mismatch expected r=%0d g=%0d b=%0d got r=%0d g=%0d b=%0d",
                       want.red, want.green, want.blue, red_o, green_o, blue_o);
            end
          end
        end
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IdleLimit) begin
          $display("tb: no progress for %0d cycles", IdleLimit);
          $display("tb: errors");
          $finish;
        end
      end
    end
  end

  initial begin
    hsl_row_t row;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    hue_i          = 16'd0;
    saturation_i   = 16'd0;
    lightness_i    = 16'd0;
    out_stall_i    = 1'b0;
    stall_left     = 0;
    calm           = 1'b0;
    requests_sent  = 0;
    colors_checked = 0;
    bad_colors     = 0;
    idle_cycles    = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (edge_rows[i]) begin
      send_request(edge_rows[i]);
    end

    for (int n = 0; n < RandomRequests; n++) begin
      if (n == RandomRequests / 3) begin
        // hold until the pipeline has drained
        in_valid_i <= 1'b0;
        while (rgb_pending.size() != 0) @(posedge clk_i);
      end
      if (n == RandomRequests - CalmTail) begin
        calm = 1'b1;
      end
      row.hue   = pick_hue();
      row.sat   = ($urandom_range(0, 9) == 0) ? 16'd0 : pick_level();
      row.light = pick_level();
      row.typed = 1'b0;
      send_request(row);
    end

    in_valid_i <= 1'b0;
    while (rgb_pending.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("tb: %0d requests sent, %0d colors checked, %0d mismatched", requests_sent,
             colors_checked, bad_colors);
    $display("tb: covered grey, hue wrap and ramp breakpoints, clamping, idle and stall bursts");
    if (bad_colors == 0 && rgb_pending.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

// File: hsl_to_rgb_fixed_point_core.f
hdl/h2r_pkg.sv
hdl/h2r_mix.sv
hdl/h2r_chan.sv
hdl/hsl_to_rgb_fixed_point_core.sv
tb/tb.sv
